// ===== rtl/rfps_pkg.sv =====
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared widths, limits and types of the raster five-point smoother.
// ----------------------------------------------------------------------------
package rfps_pkg;

    localparam int MAX_COLS   = 32;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CNT_W      = $clog2(MAX_COLS + 1);
    localparam int PIX_W      = 8;
    localparam int CFG_COLS_W = 6;
    localparam int SUM_W      = PIX_W + 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // One unit of work for the smoothing stage: a cell, a flush cell or a
    // window priming read.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] below;
        logic             wsel;
        logic             has_right;
        logic             has_above;
        logic             emit;
        logic             first_cell;
        logic             row_close;
        logic             last_run;
        logic             frame_end;
    } t_step;

    typedef struct packed {
        logic             we;
        logic [COL_W-1:0] waddr;
        logic [PIX_W-1:0] wdata;
        logic             re;
        logic [COL_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/rfps_ram.sv =====
// ----------------------------------------------------------------------------
// rfps_ram
// Simple dual-port line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rfps_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rfps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfps_ctrl
// Raster position tracking, line store addressing and end-of-frame flush
// sequencing.
// ----------------------------------------------------------------------------
module rfps_ctrl
    import rfps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_COLS_W-1:0] i_cfg_cols,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_pixel,
    input  logic                  i_s_eof,
    input  logic                  i_take,
    output logic                  o_issue,
    output t_step                 o_step,
    output t_mem_req              o_mem_a,
    output t_mem_req              o_mem_b
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_TAIL_UP,
        ST_PRIME,
        ST_TAIL_LAST
    } t_state;

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_first_row, n_first_row;
    logic             r_sel, n_sel;
    logic [COL_W-1:0] r_j, n_j;
    logic [COL_W-1:0] r_fc, n_fc;
    logic             r_ffirst, n_ffirst;
    logic             r_fsel, n_fsel;

    logic [CNT_W-1:0] cols;
    logic [COL_W-1:0] c;
    logic [CNT_W-1:0] c_next;
    logic [CNT_W-1:0] j_next;
    logic             accept;
    logic [COL_W-1:0] w_ra;
    logic [COL_W-1:0] x_ra;
    t_step            step;
    logic             issue;

    always_comb begin
        if (i_cfg_cols < CFG_COLS_W'(2)) begin
            cols = CNT_W'(2);
        end else if (i_cfg_cols > CFG_COLS_W'(MAX_COLS)) begin
            cols = CNT_W'(MAX_COLS);
        end else begin
            cols = CNT_W'(i_cfg_cols);
        end
    end

    always_comb begin
        if (CNT_W'(r_col) >= CNT_W'(MAX_COLS)) begin
            c = COL_W'(MAX_COLS - 1);
        end else begin
            c = r_col;
        end
    end

    assign c_next     = CNT_W'(c) + CNT_W'(1);
    assign j_next     = CNT_W'(r_j) + CNT_W'(1);
    assign o_s_tready = (r_state == ST_RUN) && i_take;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        step  = '0;
        issue = 1'b0;
        w_ra  = '0;
        x_ra  = '0;
        unique case (r_state)
            ST_RUN: begin
                issue           = accept;
                step.col        = c;
                step.below      = i_s_pixel;
                step.wsel       = r_sel;
                step.has_right  = c_next < cols;
                step.has_above  = 1'b1;
                step.emit       = !r_first_row;
                step.first_cell = (c == '0);
                step.row_close  = (c_next >= cols) && !i_s_eof;
                step.last_run   = !i_s_eof;
                w_ra            = c_next[COL_W-1:0];
                x_ra            = c;
            end
            ST_TAIL_UP: begin
                issue          = i_take;
                step.col       = r_j;
                step.wsel      = r_fsel;
                step.has_right = j_next < cols;
                step.has_above = 1'b1;
                step.emit      = 1'b1;
                w_ra           = j_next[COL_W-1:0];
                x_ra           = r_j;
            end
            ST_PRIME: begin
                issue     = i_take;
                step.wsel = !r_fsel;
            end
            ST_TAIL_LAST: begin
                issue          = i_take;
                step.col       = r_j;
                step.wsel      = !r_fsel;
                step.has_right = (r_j < r_fc) && (j_next < cols);
                step.has_above = !r_ffirst;
                step.emit      = 1'b1;
                step.last_run  = (r_j == r_fc);
                step.frame_end = (r_j == r_fc);
                w_ra           = j_next[COL_W-1:0];
                x_ra           = r_j;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign o_issue = issue;
    assign o_step  = step;

    always_comb begin
        o_mem_a.re    = issue;
        o_mem_b.re    = issue;
        o_mem_a.raddr = step.wsel ? x_ra : w_ra;
        o_mem_b.raddr = step.wsel ? w_ra : x_ra;
        o_mem_a.waddr = c;
        o_mem_b.waddr = c;
        o_mem_a.we    = accept && (r_sel || r_first_row);
        o_mem_b.we    = accept && (!r_sel || r_first_row);
        o_mem_a.wdata = r_sel ? i_s_pixel : '0;
        o_mem_b.wdata = r_sel ? '0 : i_s_pixel;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_first_row = r_first_row;
        n_sel       = r_sel;
        n_j         = r_j;
        n_fc        = r_fc;
        n_ffirst    = r_ffirst;
        n_fsel      = r_fsel;
        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (i_s_eof) begin
                        n_fc        = c;
                        n_ffirst    = r_first_row;
                        n_fsel      = r_sel;
                        n_col       = '0;
                        n_first_row = 1'b1;
                        n_sel       = 1'b0;
                        if (!r_first_row && (c_next < cols)) begin
                            n_state = ST_TAIL_UP;
                            n_j     = c_next[COL_W-1:0];
                        end else begin
                            n_state = ST_PRIME;
                        end
                    end else if (c_next >= cols) begin
                        n_col       = '0;
                        n_first_row = 1'b0;
                        n_sel       = !r_sel;
                    end else begin
                        n_col = c_next[COL_W-1:0];
                    end
                end
            end
            ST_TAIL_UP: begin
                if (i_take) begin
                    if (j_next >= cols) begin
                        n_state = ST_PRIME;
                    end else begin
                        n_j = j_next[COL_W-1:0];
                    end
                end
            end
            ST_PRIME: begin
                if (i_take) begin
                    n_state = ST_TAIL_LAST;
                    n_j     = '0;
                end
            end
            ST_TAIL_LAST: begin
                if (i_take) begin
                    if (r_j == r_fc) begin
                        n_state = ST_RUN;
                    end else begin
                        n_j = j_next[COL_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_sel       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_first_row <= n_first_row;
            r_sel       <= n_sel;
        end
        r_j      <= n_j;
        r_fc     <= n_fc;
        r_ffirst <= n_ffirst;
        r_fsel   <= n_fsel;
    end

endmodule

// ===== rtl/rfps_calc.sv =====
// ----------------------------------------------------------------------------
// rfps_calc
// Smoothing stage: line store read data, three-cell window, five-point
// filter and result register.
// ----------------------------------------------------------------------------
module rfps_calc
    import rfps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_issue,
    input  t_step            i_step,
    input  logic [PIX_W-1:0] i_rdata_a,
    input  logic [PIX_W-1:0] i_rdata_b,
    output logic             o_take,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [PIX_W-1:0] o_m_smoothed,
    output logic             o_m_last,
    output logic             o_m_done
);

    logic             r_s1_valid;
    t_step            r_s1;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_centre;
    logic [PIX_W-1:0] r_first;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;
    logic             r_out_done;

    logic [PIX_W-1:0] rd_w;
    logic [PIX_W-1:0] rd_x;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] above;
    logic [SUM_W-1:0] nsum;
    logic [SUM_W-1:0] total;
    logic [SUM_W-3:0] quarter;
    logic [PIX_W:0]   half_sum;
    logic [PIX_W-1:0] result;
    logic             out_free;
    logic             s1_adv;

    assign rd_w = r_s1.wsel ? i_rdata_b : i_rdata_a;
    assign rd_x = r_s1.wsel ? i_rdata_a : i_rdata_b;

    assign left  = (r_s1.col != '0) ? r_left : '0;
    assign right = r_s1.has_right ? rd_w : '0;
    assign above = r_s1.has_above ? rd_x : '0;

    assign nsum  = SUM_W'(left) + SUM_W'(right) + SUM_W'(above) + SUM_W'(r_s1.below);
    assign total = nsum + SUM_W'(r_centre);

    assign quarter  = total[SUM_W-1:2];
    assign half_sum = {1'b0, nsum[PIX_W+1:2]} + {1'b0, r_centre};

    always_comb begin
        if (i_mode) begin
            result = half_sum[PIX_W:1];
        end else if (quarter > (SUM_W-2)'(PIX_MAX)) begin
            result = PIX_MAX;
        end else begin
            result = quarter[PIX_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign s1_adv   = r_s1_valid && (!r_s1.emit || out_free);
    assign o_take   = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_s1_valid <= i_issue;
            end
            if (s1_adv && r_s1.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take && i_issue) begin
            r_s1 <= i_step;
        end
        if (s1_adv) begin
            r_left   <= r_centre;
            r_centre <= r_s1.row_close ? r_first : rd_w;
            if (r_s1.first_cell) begin
                r_first <= r_s1.below;
            end
        end
        if (s1_adv && r_s1.emit) begin
            r_out_data <= result;
            r_out_last <= r_s1.last_run;
            r_out_done <= r_s1.frame_end;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_smoothed = r_out_data;
    assign o_m_last     = r_out_last;
    assign o_m_done     = r_out_done;

endmodule

// ===== rtl/raster_five_point_smoother.sv =====
// ----------------------------------------------------------------------------
// raster_five_point_smoother
// Five-point smoothing of an 8-bit raster map streamed in raster order.
//
// Input stream: one cell per request in tdata, tlast marks the final cell of
// the map. Output stream: one smoothed cell per request in tdata, tlast on
// the last result caused by an input cell, tuser on the final cell of the map.
// A cell's result leaves once the cell below it has been taken; the first
// row gives no results while it is being taken.
// Cells are taken at one per cycle while the receiver does not stall. The
// line store read and the pipeline stage are registered, and the result
// register follows them. The input cell marked end of frame starts a flush
// that walks the rest of the previous row and then the whole final row, one
// result per cycle while the receiver does not stall, plus one priming read.
// No input is taken during the flush.
// A stalled receiver holds the result register and, behind it, the pipeline
// stage and the input. Reset returns to the top of a frame; the line store
// contents need no clearing. Registers: mode at 0x0, row length at 0x4.
// ----------------------------------------------------------------------------
module raster_five_point_smoother
    import rfps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tlast,   // end_of_frame
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] smoothed
    output logic        m_axis_tlast,   // last_in_run
    output logic        m_axis_tuser    // [0] frame_done
);

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic                  r_mode;
    logic [CFG_COLS_W-1:0] r_cols;

    logic                  cfg_wr;
    logic                  take;
    logic                  issue;
    t_step                 step;
    t_mem_req              mem_a;
    t_mem_req              mem_b;
    logic [PIX_W-1:0]      rdata_a;
    logic [PIX_W-1:0]      rdata_b;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cols <= CFG_COLS_W'(32);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE: r_mode <= pwdata[0];
                REG_COLS: r_cols <= pwdata[CFG_COLS_W-1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE: prdata = {31'd0, r_mode};
            REG_COLS: prdata = {{(32 - CFG_COLS_W){1'b0}}, r_cols};
            default:  prdata = '0;
        endcase
    end

    rfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_cols (r_cols),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_pixel  (s_axis_tdata),
        .i_s_eof    (s_axis_tlast),
        .i_take     (take),
        .o_issue    (issue),
        .o_step     (step),
        .o_mem_a    (mem_a),
        .o_mem_b    (mem_b)
    );

    rfps_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (PIX_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (mem_a.we),
        .i_waddr (mem_a.waddr),
        .i_wdata (mem_a.wdata),
        .i_re    (mem_a.re),
        .i_raddr (mem_a.raddr),
        .o_rdata (rdata_a)
    );

    rfps_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (PIX_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (mem_b.we),
        .i_waddr (mem_b.waddr),
        .i_wdata (mem_b.wdata),
        .i_re    (mem_b.re),
        .i_raddr (mem_b.raddr),
        .o_rdata (rdata_b)
    );

    rfps_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_issue      (issue),
        .i_step       (step),
        .i_rdata_a    (rdata_a),
        .i_rdata_b    (rdata_b),
        .o_take       (take),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_smoothed (m_axis_tdata),
        .o_m_last     (m_axis_tlast),
        .o_m_done     (m_axis_tuser)
    );

endmodule
